// ----- hdl/fptm_pkg.sv -----
// Shared types, codes and descriptor constants of the page table manager.
package fptm_pkg;

    localparam int DEFAULT_NUM_TABLES = 16;
    localparam int ENTRIES_PER_TABLE  = 512;
    localparam int SLICE_W            = 9;
    localparam int ADDR_W             = 48;
    localparam int PAGE_W             = 36;   // address bits 47:12
    localparam int DESC_W             = 64;

    // commands
    localparam logic [1:0] CMD_MAP_BLOCK = 2'd0;
    localparam logic [1:0] CMD_MAP_PAGE  = 2'd1;
    localparam logic [1:0] CMD_UNMAP     = 2'd2;
    localparam logic [1:0] CMD_LOOKUP    = 2'd3;

    // walk levels
    localparam logic [1:0] LVL0 = 2'd0;
    localparam logic [1:0] LVL1 = 2'd1;
    localparam logic [1:0] LVL2 = 2'd2;
    localparam logic [1:0] LVL3 = 2'd3;

    // privilege levels of a 4 KB map
    localparam logic [1:0] PRIV_USER   = 2'd0;
    localparam logic [1:0] PRIV_KERNEL = 2'd1;
    localparam logic [1:0] PRIV_SHARED = 2'd2;

    // descriptor fields
    localparam logic [1:0] DESC_TABLE = 2'b11;
    localparam logic [1:0] DESC_BLOCK = 2'b01;
    localparam logic [1:0] SH_BLOCK   = 2'b11;
    localparam logic [1:0] SH_PAGE    = 2'b01;
    localparam logic [1:0] AP_USER    = 2'b01;
    localparam logic [1:0] AP_KERNEL  = 2'b00;
    localparam logic [1:0] AP_SHARED  = 2'b10;

    typedef enum logic [3:0] {
        ST_DONE           = 4'd0,
        ST_BLOCK_CONFLICT = 4'd1,
        ST_PAGE_MAPPED    = 4'd2,
        ST_NO_TABLES      = 4'd3,
        ST_L1_MISSING     = 4'd4,
        ST_L2_MISSING     = 4'd5,
        ST_L3_MISSING     = 4'd6,
        ST_BLOCK_FOUND    = 4'd7,
        ST_PAGE_MISSING   = 4'd8,
        ST_PAGE_FOUND     = 4'd9
    } t_status;

    // descriptor source for memory writes and for the result word
    typedef enum logic [2:0] {
        D_ZERO,
        D_TABLE,
        D_BLOCK,
        D_PAGE,
        D_ENTRY
    } t_dsel;

    typedef struct packed {
        logic    load;
        logic    clr_step;
        logic    rd;
        logic    wr;
        t_dsel   sel;
        logic    descend;
        logic    alloc;
        logic    finish;
        t_status fin_status;
        logic    fin_flush;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] level;
        logic       present;    // entry bit 0
        logic       is_table;   // entry bit 1
        logic       tvalid;     // entry points at a table inside the pool
        logic       pool_full;
        logic       clr_last;
    } t_dp_sts;

endpackage

// ----- hdl/four_level_page_table_manager_core.sv -----
// Four-level page table manager: top level joining controller and datapath.
//
// Channels: an input word (command, virtual/physical address, attribute index,
// privilege level) on i_in_valid/o_in_ready, one result word (status,
// descriptor, flush request) per command on o_out_valid/i_out_ready, and a
// configuration word (pool base address) on i_cfg_valid/o_cfg_ready, which
// is always ready and must only be written while no command is in flight.
// Commands are handled one at a time; each level of the walk costs a memory
// read step plus an evaluate step, a table allocation one more write step,
// and a final descriptor write one more step. A lookup or unmap that misses
// at level 0 is the shortest command, a 4 KB map that allocates three tables
// the longest. The table memory is single-ported, so its reads and writes
// take separate steps.
// After reset a clearing pass zeroes all NUM_TABLES * 512 table entries;
// no command is taken during that pass.
// A finished result sits in an output register; the next command is accepted
// while it waits, and that command holds in its last step until the receiver
// takes the pending word.
module four_level_page_table_manager_core import fptm_pkg::*; #(
    parameter int NUM_TABLES = DEFAULT_NUM_TABLES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [ADDR_W-1:0]   i_cfg_pool_base_address,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_command,
    input  logic [ADDR_W-1:0]   i_virtual_address,
    input  logic [ADDR_W-1:0]   i_physical_address,
    input  logic [2:0]          i_attribute_index,
    input  logic [1:0]          i_privilege_level,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [3:0]          o_status,
    output logic [DESC_W-1:0]   o_descriptor,
    output logic                o_flush_request
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    fptm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    fptm_dp #(
        .NUM_TABLES (NUM_TABLES)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (dp_cmd),
        .o_sts                   (dp_sts),
        .i_cfg_valid             (i_cfg_valid),
        .i_cfg_pool_base_address (i_cfg_pool_base_address),
        .i_command               (i_command),
        .i_virtual_address       (i_virtual_address),
        .i_physical_address      (i_physical_address),
        .i_attribute_index       (i_attribute_index),
        .i_privilege_level       (i_privilege_level),
        .o_status                (o_status),
        .o_descriptor            (o_descriptor),
        .o_flush_request         (o_flush_request)
    );

endmodule

// ----- hdl/fptm_dp.sv -----
// Datapath: table memory, walk registers, allocator and descriptor builders.
module fptm_dp import fptm_pkg::*; #(
    parameter int NUM_TABLES = DEFAULT_NUM_TABLES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_cfg_valid,
    input  logic [ADDR_W-1:0]   i_cfg_pool_base_address,
    input  logic [1:0]          i_command,
    input  logic [ADDR_W-1:0]   i_virtual_address,
    input  logic [ADDR_W-1:0]   i_physical_address,
    input  logic [2:0]          i_attribute_index,
    input  logic [1:0]          i_privilege_level,
    output logic [3:0]          o_status,
    output logic [DESC_W-1:0]   o_descriptor,
    output logic                o_flush_request
);

    localparam int TW    = $clog2(NUM_TABLES);
    localparam int NW    = $clog2(NUM_TABLES + 1);
    localparam int AW    = TW + SLICE_W;
    localparam int DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;

    logic [PAGE_W-1:0] r_base_page;
    logic [1:0]        r_command;
    logic [PAGE_W-1:0] r_va_page;
    logic [PAGE_W-1:0] r_pa_page;
    logic [2:0]        r_attr;
    logic [1:0]        r_priv;
    logic [TW-1:0]     r_table;
    logic [1:0]        r_level;
    logic [NW-1:0]     r_next_free;
    logic [AW-1:0]     r_clr_addr;
    logic [DESC_W-1:0] r_rdata;
    logic [3:0]        r_status;
    logic [DESC_W-1:0] r_desc;
    logic              r_flush;
    logic [DESC_W-1:0] r_mem [DEPTH];

    logic [SLICE_W-1:0] slice;
    logic [AW-1:0]      mem_addr;
    logic [PAGE_W-1:0]  diff;
    logic [PAGE_W-1:0]  link_page;
    logic               tvalid;
    logic               pool_full;
    logic [1:0]         ap;
    logic               uxn;
    logic [DESC_W-1:0]  sel_data;

    // r_va_page holds va[47:12]; each level takes its 9-bit slice
    always_comb begin
        case (r_level)
            LVL0:    slice = r_va_page[35:27];
            LVL1:    slice = r_va_page[26:18];
            LVL2:    slice = r_va_page[17:9];
            default: slice = r_va_page[8:0];
        endcase
    end

    assign mem_addr = i_cmd.clr_step ? r_clr_addr : {r_table, slice};

    // pool offset of the page the entry points at
    assign diff      = r_rdata[47:12] - r_base_page;
    assign tvalid    = r_rdata[0] && (diff < PAGE_W'(NUM_TABLES));
    assign pool_full = r_next_free >= NW'(NUM_TABLES);
    assign link_page = r_base_page + PAGE_W'(r_next_free);

    always_comb begin
        case (r_priv)
            PRIV_USER:   ap = AP_USER;
            PRIV_SHARED: ap = AP_SHARED;
            default:     ap = AP_KERNEL;
        endcase
        uxn = (r_priv == PRIV_KERNEL);
    end

    always_comb begin
        case (i_cmd.sel)
            D_TABLE: sel_data = {16'b0, link_page, 10'b0, DESC_TABLE};
            D_BLOCK: sel_data = {9'b0, 1'b1, 6'b0, r_pa_page, 1'b0, 1'b1, SH_BLOCK,
                                 2'b00, 1'b0, r_attr, DESC_BLOCK};
            D_PAGE:  sel_data = {9'b0, uxn, 6'b0, r_pa_page, 1'b0, 1'b1, SH_PAGE,
                                 ap, 1'b0, r_attr, DESC_TABLE};
            D_ENTRY: sel_data = r_rdata;
            default: sel_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[mem_addr] <= sel_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_page <= '0;
            r_next_free <= NW'(1);
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_base_page <= i_cfg_pool_base_address[47:12];
            end
            if (i_cmd.alloc) begin
                r_next_free <= r_next_free + 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_va_page <= i_virtual_address[47:12];
            r_pa_page <= i_physical_address[47:12];
            r_attr    <= i_attribute_index;
            r_priv    <= i_privilege_level;
            r_table   <= '0;
            r_level   <= LVL0;
        end else if (i_cmd.alloc) begin
            r_table <= r_next_free[TW-1:0];
            r_level <= r_level + 1'b1;
        end else if (i_cmd.descend) begin
            r_table <= diff[TW-1:0];
            r_level <= r_level + 1'b1;
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.fin_status;
            r_desc   <= sel_data;
            r_flush  <= i_cmd.fin_flush;
        end
    end

    assign o_sts.command   = r_command;
    assign o_sts.level     = r_level;
    assign o_sts.present   = r_rdata[0];
    assign o_sts.is_table  = r_rdata[1];
    assign o_sts.tvalid    = tvalid;
    assign o_sts.pool_full = pool_full;
    assign o_sts.clr_last  = (r_clr_addr == AW'(DEPTH - 1));

    assign o_status        = r_status;
    assign o_descriptor    = r_desc;
    assign o_flush_request = r_flush;

    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !pool_full)
        else $error("table allocated from an exhausted pool");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NW'(NUM_TABLES))
        else $error("free table pointer beyond pool");

    a_descend_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.descend |-> tvalid)
        else $error("walk followed an entry outside the pool");

endmodule

// ----- hdl/fptm_ctrl.sv -----
// Controller: clearing pass, per-level walk sequencing and result handoff.
module fptm_ctrl import fptm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_LINK,
        S_WRITE,
        S_DONE
    } t_state;

    t_state  r_state,      n_state;
    logic    r_out_valid,  n_out_valid;
    t_status r_fin_status, n_fin_status;
    t_dsel   r_sel,        n_sel;
    logic    r_fin_flush,  n_fin_flush;

    logic is_map;

    assign is_map = (i_sts.command == CMD_MAP_BLOCK) || (i_sts.command == CMD_MAP_PAGE);

    always_comb begin
        n_state      = r_state;
        n_fin_status = r_fin_status;
        n_sel        = r_sel;
        n_fin_flush  = r_fin_flush;
        o_cmd        = '0;
        o_cmd.sel    = D_ZERO;

        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.wr       = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                // default outcome: finish with no descriptor and no flush
                n_state      = S_DONE;
                n_sel        = D_ZERO;
                n_fin_flush  = 1'b0;
                n_fin_status = ST_DONE;
                if (is_map) begin
                    if (i_sts.level == LVL3) begin
                        if (i_sts.present) begin
                            n_fin_status = ST_PAGE_MAPPED;
                        end else begin
                            n_sel   = D_PAGE;
                            n_state = S_WRITE;
                        end
                    end else if (i_sts.level == LVL2 && i_sts.command == CMD_MAP_BLOCK) begin
                        n_sel   = D_BLOCK;
                        n_state = S_WRITE;
                    end else if (i_sts.level == LVL2 && i_sts.present && !i_sts.is_table) begin
                        n_fin_status = ST_BLOCK_CONFLICT;
                    end else if (i_sts.tvalid) begin
                        o_cmd.descend = 1'b1;
                        n_state       = S_READ;
                    end else if (i_sts.pool_full) begin
                        n_fin_status = ST_NO_TABLES;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    case (i_sts.level)
                        LVL0: begin
                            if (i_sts.tvalid) begin
                                o_cmd.descend = 1'b1;
                                n_state       = S_READ;
                            end else begin
                                n_fin_status = ST_L1_MISSING;
                            end
                        end
                        LVL1: begin
                            if (i_sts.tvalid) begin
                                o_cmd.descend = 1'b1;
                                n_state       = S_READ;
                            end else begin
                                n_fin_status = ST_L2_MISSING;
                            end
                        end
                        LVL2: begin
                            if (!i_sts.present) begin
                                n_fin_status = ST_L3_MISSING;
                            end else if (!i_sts.is_table) begin
                                // 2 MB block at this level
                                if (i_sts.command == CMD_UNMAP) begin
                                    n_fin_flush = 1'b1;
                                    n_state     = S_WRITE;
                                end else begin
                                    n_fin_status = ST_BLOCK_FOUND;
                                    n_sel        = D_ENTRY;
                                end
                            end else if (i_sts.tvalid) begin
                                o_cmd.descend = 1'b1;
                                n_state       = S_READ;
                            end else begin
                                n_fin_status = ST_L3_MISSING;
                            end
                        end
                        default: begin
                            if (i_sts.command == CMD_UNMAP) begin
                                n_fin_flush = 1'b1;
                                n_state     = S_WRITE;
                            end else if (i_sts.present) begin
                                n_fin_status = ST_PAGE_FOUND;
                                n_sel        = D_ENTRY;
                            end else begin
                                n_fin_status = ST_PAGE_MISSING;
                            end
                        end
                    endcase
                end
            end
            S_LINK: begin
                // link a fresh table at the current slot, then read into it
                o_cmd.wr    = 1'b1;
                o_cmd.sel   = D_TABLE;
                o_cmd.alloc = 1'b1;
                n_state     = S_READ;
            end
            S_WRITE: begin
                o_cmd.wr  = 1'b1;
                o_cmd.sel = r_sel;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.sel        = r_sel;
                    o_cmd.fin_status = r_fin_status;
                    o_cmd.fin_flush  = r_fin_flush;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_out_valid  <= 1'b0;
            r_fin_status <= ST_DONE;
            r_sel        <= D_ZERO;
            r_fin_flush  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_fin_status <= n_fin_status;
            r_sel        <= n_sel;
            r_fin_flush  <= n_fin_flush;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten before it was taken");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd && o_cmd.wr))
        else $error("table memory read and write in one cycle");

endmodule
